// ----- sv/icec_pkg.sv -----
// ----------------------------------------------------------------------------
// icec_pkg
// Shared types and constants for the idle countdown entry cache: the entry
// count, field widths, operation and status codes, the scan record that
// travels along the cell row and the command that is broadcast to the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package icec_pkg;

  // Table geometry.
  localparam int ENTRIES  = 16;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Field widths fixed by the interface.
  localparam int FUNC_W   = 2;
  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 4;
  localparam int STATUS_W = 3;
  localparam int CNT_W    = 16;

  // Operation codes carried in the func field.
  localparam logic [FUNC_W-1:0] FUNC_OPEN  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLOSE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_HIT    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FREE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EVICT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOIDLE = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DONE   = 3'd5;

  // Register index of timer_period, taken from paddr[2].
  localparam logic REG_TIMER_PERIOD = 1'b0;

  // Reset value of timer_period.
  localparam logic [CNT_W-1:0] TIMER_PERIOD_RESET = 16'd30;

  // One input beat.
  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic                file_exists;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] entry_handle;
  } out_item_t;

  // Search record handed from cell to cell during an open.
  typedef struct packed {
    logic             live;
    logic             hit_found;
    logic [IDX_W-1:0] hit_idx;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             idle_found;
    logic [IDX_W-1:0] idle_idx;
    logic [CNT_W:0]   idle_cnt;
  } scan_rec_t;

  // Update broadcast to every cell.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_HIT,
    OP_CLAIM,
    OP_CLOSE,
    OP_TICK
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] period;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ----- sv/icec_cell.sv -----
// ----------------------------------------------------------------------------
// icec_cell
// One table entry. It holds the entry's valid mark, key, in-use mark and
// countdown, folds its own entry into the search record that passes through
// it, and applies the update commands broadcast by the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module icec_cell
  import icec_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [IDX_W-1:0] my_idx,
  input  wire logic [KEY_W-1:0] search_key,
  input  wire scan_rec_t        scan_in,
  output scan_rec_t             scan_out,
  input  wire cell_cmd_t        cmd
);

  logic             valid;
  logic             in_use;
  logic [CNT_W-1:0] cnt;
  logic [KEY_W-1:0] key;
  scan_rec_t        scan_next;
  logic             sel;

  assign sel = (cmd.idx == my_idx);

  // Fold this entry into the passing search record.
  always_comb begin
    scan_next = scan_in;
    if (scan_in.live) begin
      if (!scan_in.hit_found && valid && (key == search_key)) begin
        scan_next.hit_found = 1'b1;
        scan_next.hit_idx   = my_idx;
      end
      if (!scan_in.free_found && !valid) begin
        scan_next.free_found = 1'b1;
        scan_next.free_idx   = my_idx;
      end
      if (!in_use && ({1'b0, cnt} < scan_in.idle_cnt)) begin
        scan_next.idle_found = 1'b1;
        scan_next.idle_idx   = my_idx;
        scan_next.idle_cnt   = {1'b0, cnt};
      end
    end
  end

  // Hand the record on to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out.live <= 1'b0;
    end else begin
      scan_out <= scan_next;
    end
  end

  // Entry control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= 1'b0;
      in_use <= 1'b0;
      cnt    <= '0;
    end else begin
      unique case (cmd.op)
        OP_HIT: begin
          if (sel) begin
            in_use <= 1'b1;
            cnt    <= cmd.period;
          end
        end
        OP_CLAIM: begin
          if (sel) begin
            valid  <= 1'b1;
            in_use <= 1'b1;
            cnt    <= cmd.period;
          end
        end
        OP_CLOSE: begin
          if (sel) begin
            in_use <= 1'b0;
          end
        end
        OP_TICK: begin
          if (!in_use && (cnt != '0)) begin
            cnt <= cnt - 1'b1;
          end
        end
        OP_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // The key is only read while the entry is valid, so it needs no reset.
  always_ff @(posedge clk) begin
    if ((cmd.op == OP_CLAIM) && sel) begin
      key <= cmd.key;
    end
  end

endmodule

`default_nettype wire

// ----- sv/idle_countdown_entry_cache.sv -----
// ----------------------------------------------------------------------------
// idle_countdown_entry_cache
// Fully associative table of entries with idle countdown replacement. An open
// sends a search record down a row of entry cells, one cell per cycle, and
// then commits a hit, a claim of a free entry or an eviction. Close and tick
// are broadcast to the cells at once.
// ----------------------------------------------------------------------------
// An open gives its result once its search record has left the last cell of
// the row and the decision has been registered; close and tick give theirs
// in the cycle after acceptance. No new item is accepted while an open is in
// progress; close and tick can be taken every cycle while no open is running.
// Results are strobed on done for one cycle; the receiver cannot stall.
// Synchronous reset frees every entry, clears all countdowns and in-use marks
// and loads timer_period with 30; the block accepts work on the next cycle.
`default_nettype none

module idle_countdown_entry_cache
  import icec_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    item,
  output logic             done,
  output out_item_t        result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t                    state;
  state_t                    state_next;
  logic [CNT_W-1:0]          timer_period;
  logic [KEY_W-1:0]          key_q;
  logic                      exists_q;
  scan_rec_t                 seed;
  scan_rec_t                 chain [ENTRIES+1];
  scan_rec_t                 fin;
  cell_cmd_t                 cmd;
  logic                      accept;
  logic                      scan_end;
  logic [HANDLE_W+IDX_W-1:0] handle_wide;
  logic                      handle_ok;
  logic                      done_next;
  logic [STATUS_W-1:0]       status_next;
  logic [IDX_W-1:0]          which_next;
  logic [IDX_W+HANDLE_W-1:0] which_wide;
  logic [ENTRIES:0]          live_vec;

  assign busy     = (state == S_SCAN);
  assign accept   = start && !busy;
  assign fin      = chain[ENTRIES];
  assign scan_end = fin.live;

  // Configuration port: single register, always ready.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_period <= TIMER_PERIOD_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_TIMER_PERIOD)) begin
      timer_period <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TIMER_PERIOD) begin
      prdata = {{(32-CNT_W){1'b0}}, timer_period};
    end
  end

  // Controller state: idle, or waiting for the record to leave the last cell.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (item.func == FUNC_OPEN)) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the open beat and launch a fresh search record into cell 0.
  always_ff @(posedge clk) begin
    if (accept && (item.func == FUNC_OPEN)) begin
      key_q    <= item.key;
      exists_q <= item.file_exists;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed.live <= 1'b0;
    end else if (accept && (item.func == FUNC_OPEN)) begin
      seed.live       <= 1'b1;
      seed.hit_found  <= 1'b0;
      seed.hit_idx    <= '0;
      seed.free_found <= 1'b0;
      seed.free_idx   <= '0;
      seed.idle_found <= 1'b0;
      seed.idle_idx   <= '0;
      seed.idle_cnt   <= {1'b0, timer_period} + 1'b1;
    end else begin
      seed.live <= 1'b0;
    end
  end

  // Row of entry cells.
  assign chain[0] = seed;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    icec_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .my_idx     (IDX_W'(g)),
      .search_key (key_q),
      .scan_in    (chain[g]),
      .scan_out   (chain[g+1]),
      .cmd        (cmd)
    );
    assign live_vec[g+1] = chain[g+1].live;
  end

  assign live_vec[0] = seed.live;

  // Close handle range check.
  assign handle_wide = {{IDX_W{1'b0}}, item.handle};
  assign handle_ok   = (handle_wide < (HANDLE_W+IDX_W)'(ENTRIES));

  // Decide the command for the cells and the next result.
  always_comb begin
    cmd.op      = OP_NONE;
    cmd.idx     = '0;
    cmd.key     = key_q;
    cmd.period  = timer_period;
    done_next   = 1'b0;
    status_next = ST_DONE;
    which_next  = '0;
    if (scan_end) begin
      done_next = 1'b1;
      priority if (fin.hit_found) begin
        status_next = ST_HIT;
        which_next  = fin.hit_idx;
        cmd.op      = OP_HIT;
        cmd.idx     = fin.hit_idx;
      end else if (!exists_q) begin
        status_next = ST_ABSENT;
      end else if (fin.free_found) begin
        status_next = ST_FREE;
        which_next  = fin.free_idx;
        cmd.op      = OP_CLAIM;
        cmd.idx     = fin.free_idx;
      end else if (fin.idle_found) begin
        status_next = ST_EVICT;
        which_next  = fin.idle_idx;
        cmd.op      = OP_CLAIM;
        cmd.idx     = fin.idle_idx;
      end else begin
        status_next = ST_NOIDLE;
      end
    end else if (accept && (item.func != FUNC_OPEN)) begin
      done_next = 1'b1;
      if (item.func == FUNC_CLOSE) begin
        if (handle_ok) begin
          cmd.op  = OP_CLOSE;
          cmd.idx = handle_wide[IDX_W-1:0];
        end
      end else if (item.func == FUNC_TICK) begin
        cmd.op = OP_TICK;
      end
    end
  end

  assign which_wide = {{HANDLE_W{1'b0}}, which_next};

  // Result register: one strobed beat per item.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (done_next) begin
      result.status       <= status_next;
      result.entry_handle <= which_wide[HANDLE_W-1:0];
    end
  end

  // Checks on the search walk and the result stream.
  a_one_record: assert property (@(posedge clk) disable iff (rst)
    $onehot0(live_vec))
    else $error("more than one search record in the cell row");

  a_scan_result: assert property (@(posedge clk) disable iff (rst)
    scan_end |=> done && !busy)
    else $error("search end did not give a result and return to idle");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result beat without an accepted item or a search");

  a_handle_zero: assert property (@(posedge clk) disable iff (rst)
    done && (result.status != ST_HIT) && (result.status != ST_FREE)
      && (result.status != ST_EVICT) |-> (result.entry_handle == '0))
    else $error("entry handle not zero for a status without an entry");

endmodule

`default_nettype wire

// ----- verif/idle_countdown_entry_cache_tb.sv -----
// ----------------------------------------------------------------------------
// idle_countdown_entry_cache_tb
// Self-checking bench for the idle countdown entry cache. A driver feeds
// command beats from a queue of pending commands and a monitor checks every
// result beat against a shadow copy of the entry table. A directed part
// covers absent files, free entry claims, hits, eviction and a full table.
// Random phases then follow, each with its own timer period and sender
// gaps. Random commands draw on a small pool of keys so that hits, evictions
// and refusals all occur. The timer period is written and read back over
// the APB port between phases while the block is idle.
// ----------------------------------------------------------------------------

module idle_countdown_entry_cache_tb
  import icec_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // The func code that no operation uses.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam int KEY_POOL     = 20;
  localparam int PHASES       = 5;
  localparam int PHASE_CMDS   = 100;
  localparam int DRAIN_CYCLES = ENTRIES + 4;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int REPORT_MAX   = 10;

  // Timer period and sender idle percentage of each random phase; a
  // period of -1 asks for a random one. The receiver cannot stall, so the
  // phase meant for receiver stalls runs with no gaps at all.
  localparam int PHASE_PERIOD [PHASES] = '{65535, 0, 7, -1, 30};
  localparam int PHASE_IDLE   [PHASES] = '{0, 74, 0, 10, 74};

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            start = 1'b0;
  logic            busy;
  in_item_t        item = '0;
  logic            done;
  out_item_t       result;
  logic            psel = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite = 1'b0;
  logic [2:0]      paddr = '0;
  logic [31:0]     pwdata = '0;
  logic [31:0]     prdata;
  logic            pready;

  idle_countdown_entry_cache uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .item    (item),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the entry table and of the timer period register.
  logic             slot_valid     [ENTRIES];
  logic [KEY_W-1:0] slot_key       [ENTRIES];
  logic             slot_in_use    [ENTRIES];
  logic [CNT_W-1:0] slot_countdown [ENTRIES];
  logic [CNT_W-1:0] period_shadow;

  in_item_t         pending_cmds[$];
  out_item_t        expected_results[$];
  logic [KEY_W-1:0] key_pool [KEY_POOL];
  int               sender_idle_pct = 0;
  int               fail_count = 0;
  logic             took_beat = 1'b0;

  // Clock.
  initial begin
    forever #5 clk = ~clk;
  end

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) begin
      $display("ERROR: %s", msg);
    end
  endtask

  // Works out the result of one command and updates the shadow table.
  function automatic out_item_t predict_cache_result(input in_item_t cmd);
    out_item_t      res;
    logic [CNT_W:0] best_cnt;
    int             sel;
    res.status       = ST_DONE;
    res.entry_handle = '0;
    sel = -1;
    case (cmd.func)
      FUNC_OPEN: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (sel < 0 && slot_valid[i] && slot_key[i] == cmd.key) sel = i;
        end
        if (sel >= 0) begin
          slot_in_use[sel]    = 1'b1;
          slot_countdown[sel] = period_shadow;
          res.status = ST_HIT;
        end else if (!cmd.file_exists) begin
          // An absent file is refused before any claim is considered.
          res.status = ST_ABSENT;
        end else begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (sel < 0 && !slot_valid[i]) sel = i;
          end
          if (sel >= 0) begin
            res.status = ST_FREE;
          end else begin
            // Smallest idle countdown wins, lowest index on ties, but only
            // countdowns no larger than the current period qualify.
            best_cnt = {1'b0, period_shadow} + 1'b1;
            for (int i = 0; i < ENTRIES; i++) begin
              if (!slot_in_use[i] && {1'b0, slot_countdown[i]} < best_cnt) begin
                sel = i;
                best_cnt = {1'b0, slot_countdown[i]};
              end
            end
            res.status = (sel >= 0) ? ST_EVICT : ST_NOIDLE;
          end
          if (sel >= 0) begin
            slot_valid[sel]     = 1'b1;
            slot_key[sel]       = cmd.key;
            slot_in_use[sel]    = 1'b1;
            slot_countdown[sel] = period_shadow;
          end
        end
        if (sel >= 0) res.entry_handle = HANDLE_W'(sel);
      end
      FUNC_CLOSE: begin
        if (int'(cmd.handle) < ENTRIES) slot_in_use[cmd.handle] = 1'b0;
      end
      FUNC_TICK: begin
        // Free entries count down as well as idle ones.
        for (int i = 0; i < ENTRIES; i++) begin
          if (!slot_in_use[i] && slot_countdown[i] != '0) begin
            slot_countdown[i] = slot_countdown[i] - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic queue_cmd(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] key,
                           input logic [HANDLE_W-1:0] handle, input logic exists);
    in_item_t c;
    c.func        = func;
    c.key         = key;
    c.handle      = handle;
    c.file_exists = exists;
    pending_cmds.push_back(c);
  endtask

  function automatic in_item_t random_cmd();
    in_item_t c;
    int       roll;
    roll          = $urandom_range(99);
    c.key         = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(KEY_POOL - 1)];
    c.handle      = HANDLE_W'($urandom_range(15));
    c.file_exists = ($urandom_range(7) != 0);
    if (roll < 50)      c.func = FUNC_OPEN;
    else if (roll < 75) c.func = FUNC_CLOSE;
    else if (roll < 95) c.func = FUNC_TICK;
    else                c.func = FUNC_UNUSED;
    return c;
  endfunction

  // Waits until every pending command has been taken and answered.
  task automatic wait_for_drain();
    while (pending_cmds.size() != 0 || start || expected_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Writes the timer period and reads it back.
  task automatic write_timer_period(input logic [CNT_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_TIMER_PERIOD, 2'b00};
    pwdata  <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    period_shadow = value;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== 32'(value)) begin
      note_failure($sformatf("timer_period read back: expected %0d, got %0d",
                             value, prdata));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Driver: offers the next command, or a gap, once the last beat is taken.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took_beat) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        item  <= pending_cmds.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks result beats and predicts each accepted command.
  always @(posedge clk) begin : monitor
    out_item_t want;
    took_beat <= !rst && start && !busy;
    if (!rst) begin
      if (done) begin
        if (expected_results.size() == 0) begin
          note_failure($sformatf("result beat with nothing expected: status %0d handle %0d",
                                 result.status, result.entry_handle));
        end else begin
          want = expected_results.pop_front();
          if (result.status !== want.status || result.entry_handle !== want.entry_handle) begin
            note_failure($sformatf("result mismatch: expected status %0d handle %0d, got status %0d handle %0d",
                                   want.status, want.entry_handle,
                                   result.status, result.entry_handle));
          end
        end
      end
      if (start && !busy) begin
        expected_results.push_back(predict_cache_result(item));
      end
    end
  end

  // Timeout.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    int period_pick;
    for (int i = 0; i < ENTRIES; i++) begin
      slot_valid[i]     = 1'b0;
      slot_key[i]       = '0;
      slot_in_use[i]    = 1'b0;
      slot_countdown[i] = '0;
    end
    period_shadow = TIMER_PERIOD_RESET;
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom;

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part at the reset period: absent file, claims, a hit, the
    // extremes of the key, close of a free entry, the unused code, a full
    // table, an eviction and a refusal when nothing is idle.
    queue_cmd(FUNC_OPEN, 32'h0000_0000, 4'h0, 1'b0);
    queue_cmd(FUNC_OPEN, 32'h0000_0000, 4'h0, 1'b1);
    queue_cmd(FUNC_OPEN, 32'hFFFF_FFFF, 4'hF, 1'b1);
    queue_cmd(FUNC_OPEN, 32'h0000_0000, 4'h0, 1'b0);
    queue_cmd(FUNC_TICK, 32'hFFFF_FFFF, 4'hF, 1'b1);
    queue_cmd(FUNC_CLOSE, 32'h0000_0000, 4'h0, 1'b0);
    queue_cmd(FUNC_CLOSE, 32'hFFFF_FFFF, 4'hF, 1'b1);
    queue_cmd(FUNC_UNUSED, 32'hFFFF_FFFF, 4'hF, 1'b1);
    for (int i = 2; i < ENTRIES; i++) begin
      queue_cmd(FUNC_OPEN, 32'(i), 4'h0, 1'b1);
    end
    queue_cmd(FUNC_OPEN, 32'hA5A5_5A5A, 4'h0, 1'b1);
    queue_cmd(FUNC_OPEN, 32'h5A5A_A5A5, 4'h0, 1'b1);
    queue_cmd(FUNC_CLOSE, 32'h0, 4'h1, 1'b0);
    wait_for_drain();

    // Random phases, each with its own period and sender gaps.
    for (int p = 0; p < PHASES; p++) begin
      repeat (DRAIN_CYCLES) @(negedge clk);
      period_pick = (PHASE_PERIOD[p] < 0) ? $urandom_range(65535) : PHASE_PERIOD[p];
      write_timer_period(CNT_W'(period_pick));
      sender_idle_pct = PHASE_IDLE[p];
      for (int i = 0; i < 4; i++) key_pool[$urandom_range(KEY_POOL - 1)] = $urandom;
      for (int i = 0; i < PHASE_CMDS; i++) pending_cmds.push_back(random_cmd());
      wait_for_drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", expected_results.size()));
    end
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/icec_pkg.sv
sv/icec_cell.sv
sv/idle_countdown_entry_cache.sv
verif/idle_countdown_entry_cache_tb.sv
